[src/efp_pkg.sv]
// ============================================================================
// efp_pkg: shared types and constants for the escape-time fractal pixel engine
// Holds the payload structs, configuration view, command/status groups and
// the controller state encoding.
// ============================================================================
package efp_pkg;

    // Fixed-point format of coordinates and iterates (signed Q4.28).
    localparam int FRAC_BITS = 28;
    // Width of a pixel index.
    localparam int DIM_BITS  = 12;
    // APB address width: eight 32-bit registers at byte offsets 4*i.
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // Escape threshold |z|^2 >= 4 on products with 2*FRAC_BITS fraction bits.
    localparam logic [64:0] ESC_LIMIT = 65'd1 << (2 * FRAC_BITS + 2);

    // Register indexes.
    localparam logic [2:0] REG_JULIA_MODE   = 3'd0;
    localparam logic [2:0] REG_MAX_ITER     = 3'd1;
    localparam logic [2:0] REG_X_ORIGIN     = 3'd2;
    localparam logic [2:0] REG_Y_ORIGIN     = 3'd3;
    localparam logic [2:0] REG_PIXEL_STEP   = 3'd4;
    localparam logic [2:0] REG_JULIA_C_REAL = 3'd5;
    localparam logic [2:0] REG_JULIA_C_IMAG = 3'd6;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd7;

    // Input item: one pixel position.
    typedef struct packed {
        logic [DIM_BITS-1:0] col;
        logic [DIM_BITS-1:0] row;
    } efp_item_t;

    // Result item: position with flipped row and the step count.
    typedef struct packed {
        logic [DIM_BITS-1:0] out_col;
        logic [DIM_BITS-1:0] out_row;
        logic [7:0]          count;
    } efp_result_t;

    // Current configuration register values.
    typedef struct packed {
        logic               julia_mode;
        logic [15:0]        max_iterations;
        logic signed [31:0] x_origin;
        logic signed [31:0] y_origin;
        logic [30:0]        pixel_step;
        logic signed [31:0] julia_c_real;
        logic signed [31:0] julia_c_imag;
        logic [12:0]        frame_height;
    } efp_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // capture col/row, clear step count
        logic point_mul;   // multipliers take col*step and row*step
        logic point_add;   // form the point, load initial z and c
        logic iter_upd;    // write new z and bump the step count
        logic out_load;    // capture the result payload
    } efp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic escape;      // |z|^2 >= 4 on the registered products
        logic limit_hit;   // step count has reached max_iterations
    } efp_status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_POINT_MUL,
        S_POINT_ADD,
        S_ITER_MUL,
        S_ITER_UPD,
        S_FINISH
    } efp_state_t;

endpackage

[src/escape_time_fractal_pixel.sv]
// ============================================================================
// escape_time_fractal_pixel: Mandelbrot / Julia escape-time pixel engine
// Maps a pixel to a Q4.28 point, iterates z = z^2 + c and returns the
// step count modulo 256 with the row flipped.
// ============================================================================
//
//   Channel  | Direction | Handshake               | Payload
//   ---------+-----------+-------------------------+--------------------------
//   item     | in        | item_valid / item_stall | col, row
//   result   | out       | result_valid / stall    | out_col, out_row, count
//   apb      | in/out    | psel, penable, pready   | paddr, pwdata, prdata
//
// Each step has a multiply state for the three products and an update
// state for the escape test and the new iterate. A pixel that escapes
// leaves the loop from the update state, one that reaches the limit
// from the multiply state.
// Reset returns the engine to idle with no result pending; registers take
// their default values.
// A new pixel is taken as soon as the previous result is parked in the
// output register; a stalled result holds the engine only at its finish.
//
module escape_time_fractal_pixel
    import efp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_stall,
    input  efp_item_t         item,
    output logic              result_valid,
    input  logic              result_stall,
    output efp_result_t       result
);

    efp_cfg_t    cfg;
    efp_cmd_t    cmd;
    efp_status_t status;

    // Configuration registers.
    efp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    efp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Arithmetic.
    efp_datapath u_datapath (
        .clk    (clk),
        .cfg    (cfg),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

[src/efp_cfg.sv]
// ============================================================================
// efp_cfg: APB configuration register file
// Eight registers at byte offsets 4*i, written on the access phase of a
// write transfer and read back zero-extended.
// ============================================================================
module efp_cfg
    import efp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output efp_cfg_t          cfg
);

    logic               julia_mode_reg;
    logic [15:0]        max_iter_reg;
    logic signed [31:0] x_origin_reg;
    logic signed [31:0] y_origin_reg;
    logic [30:0]        pixel_step_reg;
    logic signed [31:0] julia_c_real_reg;
    logic signed [31:0] julia_c_imag_reg;
    logic [12:0]        frame_height_reg;
    logic               wr_en;
    logic [2:0]         reg_idx;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            julia_mode_reg   <= 1'b0;
            max_iter_reg     <= 16'd255;
            x_origin_reg     <= '0;
            y_origin_reg     <= '0;
            pixel_step_reg   <= 31'd1048576;
            julia_c_real_reg <= '0;
            julia_c_imag_reg <= '0;
            frame_height_reg <= 13'd1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_JULIA_MODE:   julia_mode_reg   <= pwdata[0];
                REG_MAX_ITER:     max_iter_reg     <= pwdata[15:0];
                REG_X_ORIGIN:     x_origin_reg     <= signed'(pwdata);
                REG_Y_ORIGIN:     y_origin_reg     <= signed'(pwdata);
                REG_PIXEL_STEP:   pixel_step_reg   <= pwdata[30:0];
                REG_JULIA_C_REAL: julia_c_real_reg <= signed'(pwdata);
                REG_JULIA_C_IMAG: julia_c_imag_reg <= signed'(pwdata);
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[12:0];
                default:          ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (reg_idx)
            REG_JULIA_MODE:   prdata = {31'd0, julia_mode_reg};
            REG_MAX_ITER:     prdata = {16'd0, max_iter_reg};
            REG_X_ORIGIN:     prdata = x_origin_reg;
            REG_Y_ORIGIN:     prdata = y_origin_reg;
            REG_PIXEL_STEP:   prdata = {1'b0, pixel_step_reg};
            REG_JULIA_C_REAL: prdata = julia_c_real_reg;
            REG_JULIA_C_IMAG: prdata = julia_c_imag_reg;
            REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.julia_mode     = julia_mode_reg;
    assign cfg.max_iterations = max_iter_reg;
    assign cfg.x_origin       = x_origin_reg;
    assign cfg.y_origin       = y_origin_reg;
    assign cfg.pixel_step     = pixel_step_reg;
    assign cfg.julia_c_real   = julia_c_real_reg;
    assign cfg.julia_c_imag   = julia_c_imag_reg;
    assign cfg.frame_height   = frame_height_reg;

endmodule

[src/efp_datapath.sv]
// ============================================================================
// efp_datapath: point generation and complex iteration datapath
// Three 32x32 signed multipliers feed registered products; the update step
// tests them for escape and forms the next iterate with saturation.
// ============================================================================
module efp_datapath
    import efp_pkg::*;
(
    input  logic        clk,
    input  efp_cfg_t    cfg,
    input  efp_item_t   item,
    input  efp_cmd_t    cmd,
    output efp_status_t status,
    output efp_result_t result
);

    // Width of a point sum: origin plus a 43-bit index*step product.
    localparam int PT_W = DIM_BITS + 33;
    // Widths of the rescaled real and imaginary products.
    localparam int RE_W = 64 - FRAC_BITS;
    localparam int IM_W = 65 - FRAC_BITS;

    logic [DIM_BITS-1:0] col_reg;
    logic [DIM_BITS-1:0] row_reg;
    logic [15:0]         step_reg;
    logic signed [31:0]  za_reg;
    logic signed [31:0]  zb_reg;
    logic signed [31:0]  ca_reg;
    logic signed [31:0]  cb_reg;
    logic signed [63:0]  aa_reg;
    logic signed [63:0]  bb_reg;
    logic signed [63:0]  ab_reg;
    efp_result_t         result_reg;

    logic signed [31:0]   m0_x;
    logic signed [31:0]   m0_y;
    logic signed [31:0]   m1_x;
    logic signed [31:0]   m1_y;
    logic signed [PT_W-1:0] px_sum;
    logic signed [PT_W-1:0] py_sum;
    logic signed [31:0]   px;
    logic signed [31:0]   py;
    logic [64:0]          mag_sq;
    logic signed [63:0]   diff;
    logic signed [RE_W-1:0] re_sh;
    logic signed [IM_W-1:0] im_sh;
    logic signed [RE_W:0] re_new;
    logic signed [IM_W:0] im_new;

    // Clamp a wide signed value into the 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -48'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // Multiplier operands: index times step while forming the point,
    // the iterate's squares otherwise.
    always_comb
    begin
        if (cmd.point_mul)
        begin
            m0_x = signed'({{(32-DIM_BITS){1'b0}}, col_reg});
            m0_y = signed'({1'b0, cfg.pixel_step});
            m1_x = signed'({{(32-DIM_BITS){1'b0}}, row_reg});
            m1_y = signed'({1'b0, cfg.pixel_step});
        end
        else
        begin
            m0_x = za_reg;
            m0_y = za_reg;
            m1_x = zb_reg;
            m1_y = zb_reg;
        end
    end

    // Point coordinates, saturated to 32 bits.
    assign px_sum = PT_W'(cfg.x_origin) + signed'(aa_reg[PT_W-1:0]);
    assign py_sum = PT_W'(cfg.y_origin) + signed'(bb_reg[PT_W-1:0]);
    assign px     = sat32(48'(px_sum));
    assign py     = sat32(48'(py_sum));

    // Escape test on the exact squares.
    assign mag_sq = {1'b0, aa_reg} + {1'b0, bb_reg};

    // Next iterate: floor-shift the products back and add c.
    assign diff   = aa_reg - bb_reg;
    assign re_sh  = signed'(diff[63:FRAC_BITS]);
    assign im_sh  = signed'(ab_reg[63:FRAC_BITS-1]);
    assign re_new = (RE_W+1)'(re_sh) + (RE_W+1)'(ca_reg);
    assign im_new = (IM_W+1)'(im_sh) + (IM_W+1)'(cb_reg);

    // Products are registered every cycle.
    always_ff @(posedge clk)
    begin
        aa_reg <= 64'(m0_x) * 64'(m0_y);
        bb_reg <= 64'(m1_x) * 64'(m1_y);
        ab_reg <= 64'(za_reg) * 64'(zb_reg);
    end

    // Item capture, iterate state and step count.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            col_reg  <= item.col;
            row_reg  <= item.row;
            step_reg <= '0;
        end
        if (cmd.point_add)
        begin
            if (cfg.julia_mode)
            begin
                za_reg <= px;
                zb_reg <= py;
                ca_reg <= cfg.julia_c_real;
                cb_reg <= cfg.julia_c_imag;
            end
            else
            begin
                za_reg <= '0;
                zb_reg <= '0;
                ca_reg <= px;
                cb_reg <= py;
            end
        end
        if (cmd.iter_upd)
        begin
            za_reg   <= sat32(48'(re_new));
            zb_reg   <= sat32(48'(im_new));
            step_reg <= step_reg + 16'd1;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.out_col <= col_reg;
            result_reg.out_row <= cfg.frame_height[DIM_BITS-1:0]
                                  - DIM_BITS'(1) - row_reg;
            result_reg.count   <= step_reg[7:0];
        end
    end

    assign status.escape    = (mag_sq >= ESC_LIMIT);
    assign status.limit_hit = (step_reg == cfg.max_iterations);
    assign result           = result_reg;

endmodule

[src/efp_ctrl.sv]
// ============================================================================
// efp_ctrl: sequencing state machine
// Steps one pixel through point generation and the iteration loop, and
// owns the input handshake and the result valid flag.
// ============================================================================
module efp_ctrl
    import efp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    output logic        result_valid,
    input  logic        result_stall,
    input  efp_status_t status,
    output efp_cmd_t    cmd
);

    efp_state_t state_reg;
    efp_state_t state_next;
    logic       result_valid_reg;
    logic       result_valid_next;

    // State and result flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_POINT_MUL;
                end
            end
            S_POINT_MUL:
            begin
                cmd.point_mul = 1'b1;
                state_next    = S_POINT_ADD;
            end
            S_POINT_ADD:
            begin
                cmd.point_add = 1'b1;
                state_next    = S_ITER_MUL;
            end
            S_ITER_MUL:
            begin
                if (status.limit_hit)
                    state_next = S_FINISH;
                else
                    state_next = S_ITER_UPD;
            end
            S_ITER_UPD:
            begin
                if (status.escape)
                    state_next = S_FINISH;
                else
                begin
                    cmd.iter_upd = 1'b1;
                    state_next   = S_ITER_MUL;
                end
            end
            S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared once the transfer completes.
    always_comb
    begin
        if (cmd.out_load)
            result_valid_next = 1'b1;
        else if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    assign result_valid = result_valid_reg;

`ifndef SYNTHESIS
    // An accepted item always starts point generation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == S_POINT_MUL))
        else $error("accepted item did not start point generation");

    // The update cycle is only reached below the iteration limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITER_UPD) |-> !status.limit_hit)
        else $error("iterate update entered at the iteration limit");

    // A waiting result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |-> !cmd.out_load)
        else $error("result overwritten while stalled");

    // Iterate updates only happen when the point has not escaped.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.iter_upd |-> (!status.escape && state_reg == S_ITER_UPD))
        else $error("iterate updated after escape");
`endif

endmodule

[sim/tb_escape_time_fractal_pixel.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_escape_time_fractal_pixel: self-checking bench for the fractal pixel engine
// Programs the view through the APB port, sends pixel positions and checks
// every returned pixel (column, flipped row, step count) against a local
// fixed-point iteration of z = z^2 + c in Mandelbrot and Julia modes.
// ============================================================================
module tb_escape_time_fractal_pixel;
    import efp_pkg::*;

    localparam longint unsigned ESCAPE_SQ   = 64'd4 << (2 * FRAC_BITS);
    localparam int              HOLD_CYCLES = 800;
    localparam int              CYCLE_LIMIT = 3000000;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    efp_item_t         pixel_in     = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    efp_result_t       pixel_out;

    // Local copy of the view registers and the pixels still owed by the engine.
    efp_cfg_t          engine_cfg;
    efp_result_t       computed_pixels[$];
    efp_result_t       oldest;
    int                mismatch_count = 0;
    int                cycle_count    = 0;

    // Sender and receiver pacing.
    int                gap_max        = 0;
    int                burst_left     = 0;
    int                stall_pct      = 0;
    int                stall_run      = 0;
    int                hold_left      = 0;
    int                hold_requests  = 0;
    int                holds_served   = 0;

    escape_time_fractal_pixel u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (pixel_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (pixel_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Saturate a coordinate or iterate part to the signed 32-bit range.
    function automatic longint clamp_q428(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Escape-time iteration of one pixel under the given view.
    function automatic efp_result_t iterate_pixel(input efp_item_t px, input efp_cfg_t cfg);
        longint          re_pt;
        longint          im_pt;
        longint          za;
        longint          zb;
        longint          ca;
        longint          cb;
        longint          aa;
        longint          bb;
        longint          ab;
        longint unsigned mag;
        int unsigned     steps;
        bit              escaped;
        logic [12:0]     flipped;
        efp_result_t     res;
        re_pt = clamp_q428(longint'(signed'(cfg.x_origin))
                           + longint'({52'd0, px.col}) * longint'({33'd0, cfg.pixel_step}));
        im_pt = clamp_q428(longint'(signed'(cfg.y_origin))
                           + longint'({52'd0, px.row}) * longint'({33'd0, cfg.pixel_step}));
        if (cfg.julia_mode)
        begin
            za = re_pt;
            zb = im_pt;
            ca = longint'(signed'(cfg.julia_c_real));
            cb = longint'(signed'(cfg.julia_c_imag));
        end
        else
        begin
            za = 0;
            zb = 0;
            ca = re_pt;
            cb = im_pt;
        end
        steps   = 0;
        escaped = 1'b0;
        while (!escaped && steps < cfg.max_iterations)
        begin
            aa  = za * za;
            bb  = zb * zb;
            ab  = za * zb;
            mag = $unsigned(aa) + $unsigned(bb);
            if (mag >= ESCAPE_SQ)
                escaped = 1'b1;
            else
            begin
                // Arithmetic shifts on signed values round toward minus infinity.
                za = clamp_q428(((aa - bb) >>> FRAC_BITS) + ca);
                zb = clamp_q428((ab >>> (FRAC_BITS - 1)) + cb);
                steps++;
            end
        end
        flipped     = cfg.frame_height - 13'd1 - {1'b0, px.row};
        res.out_col = px.col;
        res.out_row = flipped[DIM_BITS-1:0];
        res.count   = steps[7:0];
        return res;
    endfunction

    // Stop the sender and wait until every owed pixel has come back.
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (computed_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One APB write (setup then access), mirrored into the local view.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_JULIA_MODE:   engine_cfg.julia_mode     = value[0];
            REG_MAX_ITER:     engine_cfg.max_iterations = value[15:0];
            REG_X_ORIGIN:     engine_cfg.x_origin       = value;
            REG_Y_ORIGIN:     engine_cfg.y_origin       = value;
            REG_PIXEL_STEP:   engine_cfg.pixel_step     = value[30:0];
            REG_JULIA_C_REAL: engine_cfg.julia_c_real   = value;
            REG_JULIA_C_IMAG: engine_cfg.julia_c_imag   = value;
            REG_FRAME_HEIGHT: engine_cfg.frame_height   = value[12:0];
            default: ;
        endcase
    endtask

    // Offer one pixel and hold it until the transfer takes place.
    task automatic send_pixel(input logic [DIM_BITS-1:0] col, input logic [DIM_BITS-1:0] row);
        efp_item_t px;
        px.col = col;
        px.row = row;
        item_valid <= 1'b1;
        pixel_in   <= px;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        computed_pixels.push_back(iterate_pixel(px, engine_cfg));
    endtask

    // Bursts of back-to-back pixels separated by random gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(24, 1);
            gap        = $urandom_range(gap_max, 0);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Mostly pixels inside a 64x64 window of the view, some anywhere.
    task automatic send_random_pixel();
        logic [DIM_BITS-1:0] col;
        logic [DIM_BITS-1:0] row;
        int                  rows_in_view;
        rows_in_view = (engine_cfg.frame_height > 64) ? 64 : int'(engine_cfg.frame_height);
        if ($urandom_range(3, 0) == 0)
            col = 12'($urandom_range(4095, 0));
        else
            col = 12'($urandom_range(63, 0));
        if ($urandom_range(3, 0) == 0)
            row = 12'($urandom_range(4095, 0));
        else
            row = 12'($urandom_range(rows_in_view - 1, 0));
        pace_sender();
        send_pixel(col, row);
    endtask

    // Random view over the interesting part of either fractal.
    task automatic program_view(input int iter_lo, input int iter_hi);
        logic julia;
        julia = 1'($urandom_range(1, 0));
        apb_write(REG_JULIA_MODE, {31'd0, julia});
        apb_write(REG_MAX_ITER, 32'($urandom_range(iter_hi, iter_lo)));
        if (julia)
        begin
            apb_write(REG_X_ORIGIN, 32'(-429496730 + int'($urandom_range(268435456, 0))));
            apb_write(REG_Y_ORIGIN, 32'(-322122547 + int'($urandom_range(214748365, 0))));
        end
        else
        begin
            apb_write(REG_X_ORIGIN, 32'(-590558003 + int'($urandom_range(322122547, 0))));
            apb_write(REG_Y_ORIGIN, 32'(-402653184 + int'($urandom_range(268435456, 0))));
        end
        apb_write(REG_PIXEL_STEP, 32'($urandom_range(16777216, 4194304)));
        apb_write(REG_JULIA_C_REAL, 32'(-268435456 + int'($urandom_range(402653184, 0))));
        apb_write(REG_JULIA_C_IMAG, 32'(-134217728 + int'($urandom_range(268435456, 0))));
        apb_write(REG_FRAME_HEIGHT, 32'($urandom_range(4096, 1)));
    endtask

    // Reset view: the origin never escapes, far columns saturate and escape,
    // and rows past the single-row frame wrap.
    task automatic test_default_view();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd1024);
        send_pixel(12'h555, 12'hAAA);
        send_pixel(12'hAAA, 12'h555);
    endtask

    // A zero iteration limit, then a zero pixel step pinning every pixel to -1.
    task automatic test_zero_limit_and_step();
        apb_write(REG_MAX_ITER, 32'd0);
        send_pixel(12'd100, 12'd0);
        apb_write(REG_MAX_ITER, 32'd40);
        apb_write(REG_PIXEL_STEP, 32'd0);
        apb_write(REG_X_ORIGIN, 32'hF000_0000);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd5, 12'd0);
    endtask

    // Points beyond the top of the 32-bit range saturate; points at its bottom end are kept.
    task automatic test_point_saturation();
        apb_write(REG_X_ORIGIN, 32'h7FFF_FFFF);
        apb_write(REG_Y_ORIGIN, 32'h8000_0000);
        apb_write(REG_PIXEL_STEP, 32'h7FFF_FFFF);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd0, 12'd0);
        apb_write(REG_X_ORIGIN, 32'h8000_0000);
        apb_write(REG_Y_ORIGIN, 32'd0);
        send_pixel(12'd0, 12'd0);
    endtask

    // Row flip with empty, full-size and oversized frame heights.
    task automatic test_row_flip();
        apb_write(REG_FRAME_HEIGHT, 32'd0);
        send_pixel(12'd7, 12'd0);
        apb_write(REG_FRAME_HEIGHT, 32'd4096);
        send_pixel(12'd7, 12'd4095);
        send_pixel(12'd7, 12'd0);
        apb_write(REG_FRAME_HEIGHT, 32'd8191);
        send_pixel(12'd7, 12'd4095);
    endtask

    // Julia mode: an extreme constant pushes the first iterate past the range;
    // a zero constant at the origin runs to the limit.
    task automatic test_julia_saturation();
        apb_write(REG_JULIA_MODE, 32'd1);
        apb_write(REG_JULIA_C_REAL, 32'h7FFF_FFFF);
        apb_write(REG_JULIA_C_IMAG, 32'h8000_0000);
        apb_write(REG_PIXEL_STEP, 32'd0);
        apb_write(REG_X_ORIGIN, 32'h1E66_6666);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        apb_write(REG_JULIA_C_REAL, 32'd0);
        apb_write(REG_JULIA_C_IMAG, 32'd0);
        apb_write(REG_X_ORIGIN, 32'd0);
        send_pixel(12'd9, 12'd9);
    endtask

    // Largest iteration limit on a point inside the set: count wraps to 255.
    task automatic test_long_limit();
        apb_write(REG_JULIA_MODE, 32'd0);
        apb_write(REG_MAX_ITER, 32'd65535);
        send_pixel(12'd1, 12'd2);
    endtask

    // Receiver holds off while the sender keeps offering, so the engine fills up.
    task automatic test_backpressure();
        int n;
        program_view(8, 20);
        gap_max   = 0;
        stall_pct = 0;
        hold_requests++;
        for (n = 0; n < 50; n++)
            send_random_pixel();
    endtask

    // Random views with varying sender gaps and receiver stalls.
    task automatic test_random_views();
        int view;
        int n;
        for (view = 0; view < 8; view++)
        begin
            case (view % 4)
                0:
                begin
                    gap_max   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_max   = 3;
                    stall_pct = 25;
                end
                2:
                begin
                    gap_max   = 12;
                    stall_pct = 50;
                end
                default:
                begin
                    gap_max   = 40;
                    stall_pct = 80;
                end
            endcase
            if (view == 5)
                program_view(200, 255);
            else
                program_view(1, 80);
            for (n = 0; n < 225; n++)
                send_random_pixel();
        end
    endtask

    // Receiver stall pattern: random runs, plus a long hold on request.
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
            result_stall <= 1'b1;
        end
        else if ($urandom_range(99, 0) < stall_pct)
        begin
            stall_run = $urandom_range(5, 0);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Compare each transfer on the result side with the oldest owed pixel.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (computed_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel col %0d row %0d count %0d", $time,
                         pixel_out.out_col, pixel_out.out_row, pixel_out.count);
                mismatch_count++;
            end
            else
            begin
                oldest = computed_pixels.pop_front();
                if (pixel_out.out_col !== oldest.out_col)
                begin
                    $display("%0t: out_col expected %0d actual %0d", $time,
                             oldest.out_col, pixel_out.out_col);
                    mismatch_count++;
                end
                if (pixel_out.out_row !== oldest.out_row)
                begin
                    $display("%0t: out_row expected %0d actual %0d (col %0d)", $time,
                             oldest.out_row, pixel_out.out_row, oldest.out_col);
                    mismatch_count++;
                end
                if (pixel_out.count !== oldest.count)
                begin
                    $display("%0t: count expected %0d actual %0d (col %0d)", $time,
                             oldest.count, pixel_out.count, oldest.out_col);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d pixels outstanding", $time,
                     computed_pixels.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int settle;
        engine_cfg                = '0;
        engine_cfg.max_iterations = 16'd255;
        engine_cfg.pixel_step     = 31'd1048576;
        engine_cfg.frame_height   = 13'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_view();
        test_zero_limit_and_step();
        test_point_saturation();
        test_row_flip();
        test_julia_saturation();
        test_long_limit();
        test_backpressure();
        test_random_views();

        // Drain, then give any stray result time to show up.
        wait_idle();
        settle = 2 * int'(engine_cfg.max_iterations) + 8;
        if (settle > 600)
            settle = 600;
        repeat (settle) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
src/efp_pkg.sv
src/efp_cfg.sv
src/efp_datapath.sv
src/efp_ctrl.sv
src/escape_time_fractal_pixel.sv
sim/tb_escape_time_fractal_pixel.sv
